/* design/terg_pkg.sv */
package terg_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SEND   = 2'd2,
    OP_TOGGLE = 2'd3
  } op_t;

  // configuration register indexes (byte address 4*i)
  typedef enum logic [1:0] {
    REG_IDLE_LEVEL    = 2'd0,
    REG_TIMEOUT_TICK  = 2'd1,
    REG_REPEAT_OFFSET = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned TIME_W      = 16;

  localparam logic              IDLE_LEVEL_RST    = 1'b1;
  localparam logic [TIME_W-1:0] TIMEOUT_TICK_RST  = 16'd1000;
  localparam logic [TIME_W-1:0] REPEAT_OFFSET_RST = 16'd1000;

  // one result word
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic pass_number;
    logic edge_made;
  } res_t;

endpackage

/* design/terg_table.sv */
module terg_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned AW          = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [terg_pkg::TIME_W-1:0]   wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [terg_pkg::TIME_W-1:0]   rd_data,
  output logic                          clearing
);

  logic [terg_pkg::TIME_W-1:0] mem [TABLE_DEPTH];
  logic [AW-1:0]               clr_addr;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [terg_pkg::TIME_W-1:0] wdata;

  // clearing sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port shared by the sweep and table writes
  always_comb begin
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = wr_en;
      waddr = wr_addr;
      wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, new data passed through on a same-address write
  always_ff @(posedge clk) begin
    if (we && (waddr == rd_addr)) begin
      rd_data <= wdata;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/timed_edge_replay_generator.sv */
// results: each result word is registered into the output stage, or into a skid
// stage that holds one result while the output is stalled
// throughput: one input word per cycle; input stalls when both output stages are full
// reset: synchronous, sets control state with a send left pending and starts a sweep
// that zeroes all TABLE_DEPTH edge table entries; no input word is taken during the sweep
// the table is a single-port-write memory read at the next pointer each cycle
module timed_edge_replay_generator #(
  parameter int unsigned TABLE_DEPTH   = 64,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [5:0]                    table_index,
  input  logic [terg_pkg::TIME_W-1:0]   table_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          line_level,
  output logic                          busy_res,
  output logic                          pass_number,
  output logic                          edge_made,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [terg_pkg::ADDR_W-1:0]   paddr,
  input  logic [terg_pkg::DATA_W-1:0]   pwdata,
  output logic [terg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (AW > 6) ? AW : 6;
  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned TW = terg_pkg::TIME_W;

  // configuration registers
  logic          idle_level;
  logic [TW-1:0] timeout_tick;
  logic [TW-1:0] repeat_offset;
  terg_pkg::reg_idx_t reg_sel;

  // control state
  logic [PW-1:0] entry_pointer, entry_pointer_next;
  logic [CW-1:0] tick_counter, tick_counter_next;
  logic          pass_flag, pass_flag_next;
  logic          sending_flag, sending_flag_next;
  logic          pending_flag, pending_flag_next;
  logic          line_state, line_state_next;
  logic          entry_ok;

  // table port
  logic          clearing;
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [TW-1:0] tbl_rdata;
  logic [IW-1:0] idx_w;

  // result path
  terg_pkg::op_t op;
  terg_pkg::res_t res, out_word, skid_word;
  logic          skid_valid;
  logic          accept;
  logic          edge_now;
  logic [CW-1:0] cnt_inc;
  logic [TW-1:0] cur_entry;
  logic [TW:0]   due;

  assign reg_sel = terg_pkg::reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  // apb register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level    <= terg_pkg::IDLE_LEVEL_RST;
      timeout_tick  <= terg_pkg::TIMEOUT_TICK_RST;
      repeat_offset <= terg_pkg::REPEAT_OFFSET_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        terg_pkg::REG_IDLE_LEVEL:    idle_level    <= pwdata[0];
        terg_pkg::REG_TIMEOUT_TICK:  timeout_tick  <= pwdata[TW-1:0];
        terg_pkg::REG_REPEAT_OFFSET: repeat_offset <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // apb read mux
  always_comb begin
    unique case (reg_sel)
      terg_pkg::REG_IDLE_LEVEL:    prdata = terg_pkg::DATA_W'(idle_level);
      terg_pkg::REG_TIMEOUT_TICK:  prdata = terg_pkg::DATA_W'(timeout_tick);
      terg_pkg::REG_REPEAT_OFFSET: prdata = terg_pkg::DATA_W'(repeat_offset);
      default:                     prdata = '0;
    endcase
  end

  assign in_ready = !skid_valid && !clearing;
  assign accept   = in_valid && in_ready;
  assign op       = terg_pkg::op_t'(operation);

  // table write decode
  assign idx_w     = IW'(table_index);
  assign tbl_waddr = idx_w[AW-1:0];
  assign tbl_we    = accept && (op == terg_pkg::OP_WRITE)
                     && ({1'b0, idx_w} < (IW+1)'(TABLE_DEPTH));

  // current edge time, zero past the table end
  assign cur_entry = entry_ok ? tbl_rdata : '0;
  assign cnt_inc   = tick_counter + 1'b1;
  assign due       = {1'b0, cur_entry} + (pass_flag ? {1'b0, repeat_offset} : '0);

  // next state for one word
  always_comb begin
    entry_pointer_next = entry_pointer;
    tick_counter_next  = tick_counter;
    pass_flag_next     = pass_flag;
    sending_flag_next  = sending_flag;
    pending_flag_next  = pending_flag;
    line_state_next    = line_state;
    edge_now           = 1'b0;
    if (accept) begin
      unique case (op)
        terg_pkg::OP_TICK: begin
          tick_counter_next = cnt_inc;
          if (!sending_flag) begin
            // idle: restore the idle level at timeout, and start any pending send
            if ((cnt_inc == CW'(timeout_tick)) && (line_state != idle_level)) begin
              line_state_next = ~line_state;
              edge_now        = 1'b1;
            end
            if (pending_flag) begin
              entry_pointer_next = '0;
              tick_counter_next  = '0;
              pending_flag_next  = 1'b0;
              sending_flag_next  = 1'b1;
            end
          end else if (cur_entry == '0) begin
            // end of list: replay once, then stop
            if (pass_flag) begin
              sending_flag_next = 1'b0;
              pass_flag_next    = 1'b0;
            end else begin
              entry_pointer_next = '0;
              pass_flag_next     = 1'b1;
            end
          end else if (cnt_inc >= CW'(due)) begin
            line_state_next    = ~line_state;
            entry_pointer_next = entry_pointer + 1'b1;
            edge_now           = 1'b1;
          end
        end
        terg_pkg::OP_WRITE: ;
        terg_pkg::OP_SEND: begin
          pending_flag_next = 1'b1;
        end
        terg_pkg::OP_TOGGLE: begin
          line_state_next = ~line_state;
          edge_now        = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pointer <= '0;
      tick_counter  <= '0;
      pass_flag     <= 1'b0;
      sending_flag  <= 1'b0;
      pending_flag  <= 1'b1;
      line_state    <= ~terg_pkg::IDLE_LEVEL_RST;
      entry_ok      <= 1'b1;
    end else begin
      entry_pointer <= entry_pointer_next;
      tick_counter  <= tick_counter_next;
      pass_flag     <= pass_flag_next;
      sending_flag  <= sending_flag_next;
      pending_flag  <= pending_flag_next;
      line_state    <= line_state_next;
      entry_ok      <= (entry_pointer_next < PW'(TABLE_DEPTH));
    end
  end

  // edge table, read at the next pointer so the entry is ready next cycle
  terg_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tbl_we),
    .wr_addr  (tbl_waddr),
    .wr_data  (table_value),
    .rd_addr  (entry_pointer_next[AW-1:0]),
    .rd_data  (tbl_rdata),
    .clearing (clearing)
  );

  // result word for this item
  always_comb begin
    res.line_level  = line_state_next;
    res.busy_res    = sending_flag_next;
    res.pass_number = pass_flag_next;
    res.edge_made   = edge_now;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else begin
        out_word <= res;
      end
    end else if (accept) begin
      skid_word <= res;
    end
  end

  assign line_level  = out_word.line_level;
  assign busy_res    = out_word.busy_res;
  assign pass_number = out_word.pass_number;
  assign edge_made   = out_word.edge_made;

endmodule
